// File: sv/ebr_pkg.sv
package ebr_pkg;

    // Field widths of the input item.
    localparam int SAMPLE_BITS = 10;
    localparam int TIME_BITS   = 32;

    // Register and result widths.
    localparam int THRESH_BITS   = 10;
    localparam int INTERVAL_BITS = 16;
    localparam int RATE_BITS     = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    // The sample and threshold are compared at the wider of the two widths.
    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    // Bit counters of the two serial units.
    localparam int IV_CNT_BITS  = $clog2(TIME_BITS);
    localparam int DIV_CNT_BITS = $clog2(RATE_BITS);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_BEAT_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_INTERVAL   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_INTERVAL   = 2'd2;

    // Reset values and the dividend of the rate.
    localparam logic [THRESH_BITS-1:0]   THRESH_RESET  = 10'd512;
    localparam logic [INTERVAL_BITS-1:0] MIN_RESET     = 16'd300;
    localparam logic [INTERVAL_BITS-1:0] MAX_RESET     = 16'd2000;
    localparam logic [RATE_BITS-1:0]     RATE_RESET    = 16'd60;
    localparam logic [RATE_BITS-1:0]     MS_PER_MINUTE = 16'd60000;

    typedef struct packed {
        logic done;
        logic in_range;
    } iv_status_t;

endpackage

// File: sv/ecg_beat_rate_detector.sv
// Flow: a sample that is no beat goes from ST_IDLE through ST_DONE into the output register;
// a beat goes through the bit-serial interval subtractor (ST_SUB) and, when the interval is in
// range, the bit-serial divider (ST_DIV) that recomputes the rate, before ST_DONE. ST_DONE waits
// while the output register is full and not read. Throughput: one item at a time; the next item
// is taken the cycle after the result has moved into the output register.
// Reset (aresetn, synchronous, active low) restores the control registers and the rate of 60.
module ecg_beat_rate_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ebr_pkg::SAMPLE_BITS-1:0]    s_sample,
    input  logic [ebr_pkg::TIME_BITS-1:0]      s_time_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ebr_pkg::RATE_BITS-1:0]      m_rate_bpm,
    output logic                               m_beat_seen,
    output logic                               m_rate_updated,
    input  logic                               cfg_wr_en,
    input  logic [ebr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ebr_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);
    import ebr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUB  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]               state_reg;
    logic [THRESH_BITS-1:0]   thr_reg;
    logic [INTERVAL_BITS-1:0] min_reg;
    logic [INTERVAL_BITS-1:0] max_reg;
    logic                     above_reg;
    logic [TIME_BITS-1:0]     last_beat_reg;
    logic [RATE_BITS-1:0]     last_rate_reg;
    logic                     res_beat_reg;
    logic                     res_upd_reg;
    logic                     m_valid_reg;
    logic [RATE_BITS-1:0]     m_rate_reg;
    logic                     m_beat_reg;
    logic                     m_upd_reg;

    logic                     accept;
    logic [CMP_BITS-1:0]      sample_ext;
    logic [CMP_BITS-1:0]      thr_ext;
    logic                     beat;
    logic                     iv_start;
    logic                     div_start;
    logic                     out_free;
    iv_status_t               iv_status;
    logic [INTERVAL_BITS-1:0] interval;
    logic                     div_done;
    logic [RATE_BITS-1:0]     quotient;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign sample_ext = CMP_BITS'(s_sample);
    assign thr_ext    = CMP_BITS'(thr_reg);
    assign beat       = (sample_ext > thr_ext) && !above_reg;
    assign iv_start   = accept && beat;
    assign div_start  = (state_reg == ST_SUB) && iv_status.done && iv_status.in_range;
    assign out_free   = !m_valid_reg || m_ready;

    ebr_interval u_interval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (iv_start),
        .now      (s_time_ms),
        .last     (last_beat_reg),
        .min_ms   (min_reg),
        .max_ms   (max_reg),
        .status   (iv_status),
        .interval (interval)
    );

    ebr_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (interval),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BEAT_THRESHOLD: thr_reg <= cfg_wr_data[THRESH_BITS-1:0];
                REG_MIN_INTERVAL:   min_reg <= cfg_wr_data[INTERVAL_BITS-1:0];
                REG_MAX_INTERVAL:   max_reg <= cfg_wr_data[INTERVAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            above_reg     <= 1'b0;
            last_beat_reg <= '0;
            last_rate_reg <= RATE_RESET;
            res_beat_reg  <= 1'b0;
            res_upd_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // In ST_DONE the output register is either refilled or left waiting.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_beat_reg <= beat;
                        res_upd_reg  <= 1'b0;
                        if (beat) begin
                            // The interval unit loads the old beat time in this same cycle.
                            above_reg     <= 1'b1;
                            last_beat_reg <= s_time_ms;
                            state_reg     <= ST_SUB;
                        end else begin
                            if (sample_ext < thr_ext) begin
                                above_reg <= 1'b0;
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SUB: begin
                    if (iv_status.done) begin
                        if (iv_status.in_range) begin
                            state_reg <= ST_DIV;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        last_rate_reg <= quotient;
                        res_upd_reg   <= 1'b1;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_rate_reg <= last_rate_reg;
            m_beat_reg <= res_beat_reg;
            m_upd_reg  <= res_upd_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_rate_bpm     = m_rate_reg;
    assign m_beat_seen    = m_beat_reg;
    assign m_rate_updated = m_upd_reg;

endmodule

// File: sv/ebr_interval.sv
module ebr_interval (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ebr_pkg::TIME_BITS-1:0]     now,
    input  logic [ebr_pkg::TIME_BITS-1:0]     last,
    input  logic [ebr_pkg::INTERVAL_BITS-1:0] min_ms,
    input  logic [ebr_pkg::INTERVAL_BITS-1:0] max_ms,
    output ebr_pkg::iv_status_t               status,
    output logic [ebr_pkg::INTERVAL_BITS-1:0] interval
);
    import ebr_pkg::*;

    logic [TIME_BITS-1:0]   diff_reg;
    logic [TIME_BITS-1:0]   last_reg;
    logic [TIME_BITS-1:0]   lo_reg;
    logic [TIME_BITS-1:0]   hi_reg;
    logic                   borrow_reg;
    logic                   gt_reg;
    logic                   lt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [IV_CNT_BITS-1:0] cnt_reg;

    logic a_bit;
    logic b_bit;
    logic d_bit;
    logic borrow_next;

    // One bit of the modular subtraction per cycle, least significant first.
    assign a_bit       = diff_reg[0];
    assign b_bit       = last_reg[0];
    assign d_bit       = a_bit ^ b_bit ^ borrow_reg;
    assign borrow_next = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= IV_CNT_BITS'(TIME_BITS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // The difference bits replace the timestamp in its own shift register.
    // The compares scan LSB first, so the highest differing bit decides.
    always_ff @(posedge aclk) begin
        if (start) begin
            diff_reg   <= now;
            last_reg   <= last;
            lo_reg     <= TIME_BITS'(min_ms);
            hi_reg     <= TIME_BITS'(max_ms);
            borrow_reg <= 1'b0;
            gt_reg     <= 1'b0;
            lt_reg     <= 1'b0;
        end else if (busy_reg) begin
            diff_reg   <= {d_bit, diff_reg[TIME_BITS-1:1]};
            last_reg   <= {1'b0, last_reg[TIME_BITS-1:1]};
            lo_reg     <= {1'b0, lo_reg[TIME_BITS-1:1]};
            hi_reg     <= {1'b0, hi_reg[TIME_BITS-1:1]};
            borrow_reg <= borrow_next;
            if (d_bit != lo_reg[0]) begin
                gt_reg <= d_bit;
            end
            if (d_bit != hi_reg[0]) begin
                lt_reg <= hi_reg[0];
            end
        end
    end

    assign status.done     = done_reg;
    assign status.in_range = gt_reg & lt_reg;
    // An interval in range is below the maximum, so its upper bits are zero.
    assign interval        = diff_reg[INTERVAL_BITS-1:0];

endmodule

// File: sv/ebr_divider.sv
module ebr_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ebr_pkg::INTERVAL_BITS-1:0] divisor,
    output logic                              done,
    output logic [ebr_pkg::RATE_BITS-1:0]     quotient
);
    import ebr_pkg::*;

    logic [RATE_BITS-1:0]     q_reg;
    logic [INTERVAL_BITS-1:0] rem_reg;
    logic [INTERVAL_BITS-1:0] dvs_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_CNT_BITS-1:0]  cnt_reg;

    logic [INTERVAL_BITS:0] trial;
    logic [INTERVAL_BITS:0] trial_sub;
    logic                   q_bit;

    // Restoring division: one quotient bit per cycle. The dividend sits in
    // q_reg and is shifted out at the top while quotient bits enter below.
    assign trial     = {rem_reg, q_reg[RATE_BITS-1]};
    assign q_bit     = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(RATE_BITS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= MS_PER_MINUTE;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[RATE_BITS-2:0], q_bit};
            if (q_bit) begin
                rem_reg <= trial_sub[INTERVAL_BITS-1:0];
            end else begin
                rem_reg <= trial[INTERVAL_BITS-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
